>>> hdl/gbk_to_utf8_transcoder_unit_defines.svh
// Assertion macros for the GBK to UTF-8 transcoder.
`ifndef GBK_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define GBK_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define GBK_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) cond) \
        else $error("gbk check failed");
`define GBK_ASSERT_RST(lbl, cond) \
    lbl: assert property (@(posedge aclk) cond) \
        else $error("gbk reset check failed");
`else
`define GBK_ASSERT(lbl, cond)
`define GBK_ASSERT_RST(lbl, cond)
`endif

`endif

>>> hdl/gbk_pkg.sv
// Types and constants shared by the GBK to UTF-8 transcoder.
package gbk_pkg;

    typedef enum logic {
        FUNC_TABLE = 1'b0,
        FUNC_BYTE  = 1'b1
    } func_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_UNMAPPED  = 2'd2,
        ST_OPEN_LEAD = 2'd3
    } status_t;

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  LEAD_MIN    = 8'h81;
    localparam logic [7:0]  LEAD_MAX    = 8'hFE;
    localparam logic [7:0]  TRAIL_MIN   = 8'h40;
    localparam logic [15:0] UTF8_TWO    = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;
    localparam logic [7:0]  MASK_CONT   = 8'h3F;
    localparam logic [7:0]  MASK_LEAD2  = 8'h1F;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic        func;
        logic [15:0] table_index;
        logic [15:0] table_value;
        logic [7:0]  data_byte;
        logic        end_of_string;
    } in_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] consumed;
        logic        run_last;
    } out_t;

    // Results caused by one source byte: data bytes first, then optional status.
    typedef struct packed {
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
        logic            eos;
        logic [1:0]      status;
        logic [15:0]     consumed;
    } job_t;

endpackage

>>> hdl/gbk_tbl.sv
// Code table memory with clearing sweep after reset.
module gbk_tbl #(
    parameter int TABLE_ENTRIES = 65536,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    output logic          init_done
);
    import gbk_pkg::*;
    `include "gbk_to_utf8_transcoder_unit_defines.svh"

    logic [15:0]   mem [TABLE_ENTRIES];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          init_done_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0]   mem_wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            init_done_reg <= 1'b0;
        end else if (!init_done_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(TABLE_ENTRIES - 1)) begin
                init_done_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        mem_we = !init_done_reg || wr_en;
        mem_wa = init_done_reg ? wr_addr : clr_addr_reg;
        mem_wd = init_done_reg ? wr_data : 16'h0000;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_done = init_done_reg;

    `GBK_ASSERT(a_no_write_while_clearing, wr_en |-> init_done_reg)
    `GBK_ASSERT_RST(a_reset_restarts_clear, !aresetn |=> !init_done_reg)

endmodule

>>> hdl/gbk_dec.sv
// Source byte decoder: table lookup, stream state and result job build.
module gbk_dec #(
    parameter int TABLE_ENTRIES = 65536,
    localparam int AW = $clog2(TABLE_ENTRIES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gbk_pkg::in_t  s_data,
    input  logic          init_done,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [15:0]   wr_data,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [15:0]   rd_data,
    output logic          job_valid,
    input  logic          job_ready,
    output gbk_pkg::job_t job_out
);
    import gbk_pkg::*;
    `include "gbk_to_utf8_transcoder_unit_defines.svh"

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eos_reg;
    logic        s1_in_range_reg;

    logic        lead_pending_reg, lead_pending_next;
    logic [7:0]  lead_byte_reg, lead_byte_next;
    logic        stopped_reg, stopped_next;
    status_t     error_code_reg, error_code_next;
    logic [15:0] byte_count_reg, byte_count_next;

    logic        in_fire;
    logic        byte_fire;
    logic        s1_fire;
    logic        job_needed;
    logic [7:0]  lead_fwd;
    logic [15:0] full_addr;
    logic [15:0] code;
    logic [1:0]  add;
    logic [16:0] sum;
    job_t        job;

    always_comb begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        stopped_next      = stopped_reg;
        error_code_next   = error_code_reg;
        add               = 2'd0;
        job               = '0;
        code              = s1_in_range_reg ? rd_data : 16'h0000;

        if (!stopped_reg) begin
            if (lead_pending_reg) begin
                if (s1_byte_reg >= TRAIL_MIN && s1_byte_reg <= LEAD_MAX) begin
                    if (code == 16'h0000) begin
                        stopped_next      = 1'b1;
                        error_code_next   = ST_UNMAPPED;
                        lead_pending_next = 1'b0;
                    end else begin
                        add               = 2'd2;
                        lead_pending_next = 1'b0;
                        if (code < 16'(ASCII_LIMIT)) begin
                            job.nbytes   = 2'd1;
                            job.bytes[0] = code[7:0];
                        end else if (code < UTF8_TWO) begin
                            job.nbytes   = 2'd2;
                            job.bytes[0] = UTF8_LEAD2 | (code[13:6] & MASK_LEAD2);
                            job.bytes[1] = UTF8_CONT | (code[7:0] & MASK_CONT);
                        end else begin
                            job.nbytes   = 2'd3;
                            job.bytes[0] = UTF8_LEAD3 | {4'h0, code[15:12]};
                            job.bytes[1] = UTF8_CONT | (code[13:6] & MASK_CONT);
                            job.bytes[2] = UTF8_CONT | (code[7:0] & MASK_CONT);
                        end
                    end
                end else begin
                    stopped_next      = 1'b1;
                    error_code_next   = ST_INVALID;
                    lead_pending_next = 1'b0;
                end
            end else if (s1_byte_reg < ASCII_LIMIT) begin
                add          = 2'd1;
                job.nbytes   = 2'd1;
                job.bytes[0] = s1_byte_reg;
            end else if (s1_byte_reg >= LEAD_MIN && s1_byte_reg <= LEAD_MAX) begin
                lead_pending_next = 1'b1;
                lead_byte_next    = s1_byte_reg;
            end else begin
                stopped_next      = 1'b1;
                error_code_next   = ST_INVALID;
                lead_pending_next = 1'b0;
            end
        end

        sum             = {1'b0, byte_count_reg} + 17'(add);
        byte_count_next = sum[16] ? COUNT_MAX : sum[15:0];

        if (s1_eos_reg) begin
            job.eos      = 1'b1;
            job.status   = stopped_next ? error_code_next
                         : (lead_pending_next ? ST_OPEN_LEAD : ST_OK);
            job.consumed = byte_count_next;
            lead_pending_next = 1'b0;
            lead_byte_next    = 8'h00;
            stopped_next      = 1'b0;
            error_code_next   = ST_OK;
            byte_count_next   = 16'h0000;
        end
    end

    always_comb begin
        job_needed = (job.nbytes != 2'd0) || job.eos;
        job_valid  = s1_valid_reg && job_needed;
        job_out    = job;
        s1_fire    = s1_valid_reg && (!job_needed || job_ready);
        s_ready    = init_done && (!s1_valid_reg || s1_fire);
        in_fire    = s_valid && s_ready;
        byte_fire  = in_fire && (s_data.func == FUNC_BYTE);
        // lead byte of the item in flight is known without the table data
        lead_fwd   = s1_valid_reg ? lead_byte_next : lead_byte_reg;
        full_addr  = {lead_fwd, s_data.data_byte};
        rd_en      = byte_fire;
        rd_addr    = full_addr[AW-1:0];
        wr_en      = in_fire && (s_data.func == FUNC_TABLE)
                     && (17'(s_data.table_index) < 17'(TABLE_ENTRIES));
        wr_addr    = s_data.table_index[AW-1:0];
        wr_data    = s_data.table_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= byte_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_fire) begin
            s1_byte_reg     <= s_data.data_byte;
            s1_eos_reg      <= s_data.end_of_string;
            s1_in_range_reg <= 17'(full_addr) < 17'(TABLE_ENTRIES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
            stopped_reg      <= 1'b0;
            error_code_reg   <= ST_OK;
            byte_count_reg   <= 16'h0000;
        end else if (s1_fire) begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            stopped_reg      <= stopped_next;
            error_code_reg   <= error_code_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    `GBK_ASSERT(a_eos_clears_state,
        (s1_fire && s1_eos_reg) |=> (!stopped_reg && !lead_pending_reg
                                     && byte_count_reg == 16'h0000))
    `GBK_ASSERT(a_stopped_is_silent,
        (s1_valid_reg && stopped_reg && !s1_eos_reg) |-> !job_valid)

endmodule

>>> hdl/gbk_emit.sv
// Result serializer: one job buffer and the output register.
module gbk_emit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  gbk_pkg::job_t job_in,
    output logic          m_valid,
    input  logic          m_ready,
    output gbk_pkg::out_t m_data
);
    import gbk_pkg::*;
    `include "gbk_to_utf8_transcoder_unit_defines.svh"

    job_t  job_reg;
    logic  job_valid_reg;
    out_t  m_data_reg;
    logic  m_valid_reg;
    logic  is_data;
    logic  cur_last;
    logic  out_load;
    out_t  cur;

    always_comb begin
        is_data   = job_reg.nbytes != 2'd0;
        cur_last  = is_data ? (job_reg.nbytes == 2'd1 && !job_reg.eos) : 1'b1;
        out_load  = job_valid_reg && (!m_valid_reg || m_ready);
        job_ready = !job_valid_reg || (out_load && cur_last);
        cur.out_kind = is_data ? KIND_DATA : KIND_STATUS;
        cur.out_byte = is_data ? job_reg.bytes[0] : 8'h00;
        cur.status   = is_data ? ST_OK : job_reg.status;
        cur.consumed = is_data ? 16'h0000 : job_reg.consumed;
        cur.run_last = cur_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (job_valid && job_ready) begin
            job_valid_reg <= 1'b1;
        end else if (out_load && cur_last) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            job_reg <= job_in;
        end else if (out_load && is_data) begin
            job_reg.nbytes <= job_reg.nbytes - 2'd1;
            job_reg.bytes  <= job_reg.bytes >> 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= cur;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `GBK_ASSERT(a_job_has_work,
        job_valid_reg |-> (job_reg.nbytes != 2'd0 || job_reg.eos))
    `GBK_ASSERT(a_status_ends_run,
        (m_valid_reg && m_data_reg.out_kind == KIND_STATUS) |-> m_data_reg.run_last)

endmodule

>>> hdl/gbk_to_utf8_transcoder_unit.sv
// Top level of the GBK to UTF-8 transcoder.
// The first result of a byte passes the decode stage register, the job buffer and the
// output register on its way to m_data. Throughput: one result per cycle while m_ready
// stays high; a mapped pair yields up to three UTF-8 bytes.
// Reset: control state clears at once, then a sweep zeroes every table entry through
// its write port; s_ready stays low until the sweep ends.
module gbk_to_utf8_transcoder_unit #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gbk_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gbk_pkg::out_t m_data
);
    import gbk_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          init_done;
    logic          job_valid;
    logic          job_ready;
    job_t          job;

    gbk_tbl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_tbl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .init_done (init_done)
    );

    gbk_dec #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .init_done (init_done),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_out   (job)
    );

    gbk_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_in    (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
